@@ design/bmhpq_pkg.sv @@
// Package for the binary max-heap priority queue.
// Holds the item structs, the controller state type and the request and status codes.
// Used by binary_max_heap_priority_queue and its testbench; depends on nothing.
package bmhpq_pkg;

  // Default configuration of the heap.
  localparam int unsigned DEPTH_DEF     = 64;
  localparam int unsigned PAYLOAD_W_DEF = 32;

  // Fixed field widths of the item interface.
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PRIO_W   = 32;
  localparam int unsigned TOTAL_W  = 7;
  localparam int unsigned STATUS_W = 2;

  // Request codes.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } op_status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DN_LAST,
    S_DN_L,
    S_DN_R,
    S_PLACE,
    S_DONE
  } heap_state_t;

  typedef struct packed {
    logic                     req_type;
    logic [DATA_W-1:0]        item_data;
    logic signed [PRIO_W-1:0] item_priority;
  } in_item_t;

  typedef struct packed {
    logic                     top_valid;
    logic [DATA_W-1:0]        top_data;
    logic signed [PRIO_W-1:0] top_priority;
    logic [TOTAL_W-1:0]       entry_total;
    op_status_t               op_status;
  } out_item_t;

endpackage

@@ design/bmhpq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing; instantiated by the heap top level.
module bmhpq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/binary_max_heap_priority_queue.sv @@
// Binary max-heap priority queue: top level with the sift controller and the heap memory.
// Depends on bmhpq_pkg (types, codes, defaults) and bmhpq_ram (heap storage).
//
// This block is a priority queue of up to DEPTH entries, each a payload of PAYLOAD_WIDTH bits and
// a signed 32-bit priority, kept as a binary max-heap in one synchronous RAM. An input item is a
// push or a pop; every item returns exactly one result item with the root entry after the
// operation (zero when empty), a valid flag, the entry count and a status. A push to a full heap
// is dropped and flagged, a pop from an empty heap is ignored and flagged. Items are handled one
// at a time. A push walks a hole up from the end: each level of sift-up is one parent read
// followed by a compare and a write of the parent into the hole. A pop reads the last entry
// first, then each level of sift-down reads the left and the right child through the single
// read port of the RAM. Flagged items and the pop of the only entry skip the sift states. The
// result sits in an output register, so the next item is accepted and worked on while an earlier
// result still waits to be taken. The heap RAM needs no clearing after reset: only entries below
// the entry count are ever read.
module binary_max_heap_priority_queue
  import bmhpq_pkg::*;
#(
  parameter int unsigned DEPTH         = DEPTH_DEF,
  parameter int unsigned PAYLOAD_WIDTH = PAYLOAD_W_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Index width into the heap, count width (must hold DEPTH itself), child index width
  // (2 * index + 2 must not wrap), and width of one stored entry.
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = IW + 2;
  localparam int unsigned EW = PAYLOAD_WIDTH + PRIO_W;

  // An entry holds the payload in the upper bits and the priority in the low PRIO_W bits.
  heap_state_t     state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [IW-1:0]   hole_r, hole_nxt;
  logic [EW-1:0]   ent_r, ent_nxt;
  logic [EW-1:0]   cand_r, cand_nxt;
  logic [EW-1:0]   root_r, root_nxt;
  op_status_t      status_r, status_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  // Heap RAM ports.
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [EW-1:0]   ram_wdata;
  logic            ram_re;
  logic [IW-1:0]   ram_raddr;
  logic [EW-1:0]   ram_rdata;

  bmhpq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic in_acc;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Priorities of the read entry, the moving entry and the saved left child.
  logic signed [PRIO_W-1:0] rd_prio, ent_prio, cand_prio;
  assign rd_prio   = ram_rdata[PRIO_W-1:0];
  assign ent_prio  = ent_r[PRIO_W-1:0];
  assign cand_prio = cand_r[PRIO_W-1:0];

  // Index arithmetic around the hole.
  logic [XW-1:0] lch, rch, cnt_x;
  logic [IW-1:0] hole_m1, parent;
  assign lch     = XW'({hole_r, 1'b1});
  assign rch     = lch + XW'(1);
  assign cnt_x   = XW'(count_r);
  assign hole_m1 = hole_r - IW'(1);
  assign parent  = hole_m1 >> 1;

  // Sift-down selection. In S_DN_L only the left child exists (it is on the read port). In
  // S_DN_R the right child is on the read port and the left one sits in cand_r; the left child
  // wins a tie. The three compares run in parallel.
  logic          right_better, rd_gt_ent, cand_gt_ent;
  logic          dn_go;
  logic [EW-1:0] dn_pick;
  logic [IW-1:0] dn_idx;
  logic [XW-1:0] dn_nl;
  assign right_better = rd_prio > cand_prio;
  assign rd_gt_ent    = rd_prio > ent_prio;
  assign cand_gt_ent  = cand_prio > ent_prio;

  always_comb begin
    if (state_r == S_DN_R && !right_better) begin
      dn_pick = cand_r;
      dn_idx  = lch[IW-1:0];
      dn_go   = cand_gt_ent;
    end else if (state_r == S_DN_R) begin
      dn_pick = ram_rdata;
      dn_idx  = rch[IW-1:0];
      dn_go   = rd_gt_ent;
    end else begin
      dn_pick = ram_rdata;
      dn_idx  = lch[IW-1:0];
      dn_go   = rd_gt_ent;
    end
    dn_nl = XW'({dn_idx, 1'b1});
  end

  // Result built from the state after the operation.
  out_item_t result;
  always_comb begin
    result.top_valid    = (count_r != '0);
    result.top_data     = result.top_valid ? DATA_W'(root_r[EW-1:PRIO_W]) : '0;
    result.top_priority = result.top_valid ? root_r[PRIO_W-1:0] : '0;
    result.entry_total  = TOTAL_W'(count_r);
    result.op_status    = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hole_r     <= hole_nxt;
    ent_r      <= ent_nxt;
    cand_r     <= cand_nxt;
    root_r     <= root_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    hole_nxt      = hole_r;
    ent_nxt       = ent_r;
    cand_nxt      = cand_r;
    root_nxt      = root_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = hole_r;
    ram_wdata     = ent_r;
    ram_re        = 1'b0;
    ram_raddr     = parent;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          status_nxt = ST_OK;
          if (in_data.req_type == REQ_PUSH) begin
            if (count_r == CW'(DEPTH)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              // The new entry stays in a register while a hole walks up from the end.
              ent_nxt   = {in_data.item_data[PAYLOAD_WIDTH-1:0], in_data.item_priority};
              hole_nxt  = count_r[IW-1:0];
              count_nxt = count_r + CW'(1);
              if (count_r == '0) begin
                state_nxt = S_PLACE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = (count_r[IW-1:0] - IW'(1)) >> 1;
                state_nxt = S_UP;
              end
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              // Fetch the last entry; it moves down from a hole at the root.
              count_nxt = count_r - CW'(1);
              hole_nxt  = '0;
              if (count_r == CW'(1)) begin
                state_nxt = S_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = IW'(count_r - CW'(1));
                state_nxt = S_DN_LAST;
              end
            end
          end
        end
      end

      S_UP: begin
        // The parent of the hole is on the read port. A strictly greater new entry moves the
        // parent down into the hole and the hole climbs one level.
        if (ent_prio > rd_prio) begin
          ram_we    = 1'b1;
          ram_waddr = hole_r;
          ram_wdata = ram_rdata;
          hole_nxt  = parent;
          if (parent == '0) begin
            state_nxt = S_PLACE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = (parent - IW'(1)) >> 1;
          end
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_DN_LAST: begin
        ent_nxt = ram_rdata;
        if (XW'(1) < cnt_x) begin
          ram_re    = 1'b1;
          ram_raddr = IW'(1);
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_DN_L, S_DN_R: begin
        if (state_r == S_DN_L && rch < cnt_x) begin
          // Keep the left child and fetch the right one.
          cand_nxt  = ram_rdata;
          ram_re    = 1'b1;
          ram_raddr = rch[IW-1:0];
          state_nxt = S_DN_R;
        end else if (dn_go) begin
          // The larger child moves up into the hole and the hole drops one level.
          ram_we    = 1'b1;
          ram_waddr = hole_r;
          ram_wdata = dn_pick;
          if (hole_r == '0) begin
            root_nxt = dn_pick;
          end
          hole_nxt = dn_idx;
          if (dn_nl < cnt_x) begin
            ram_re    = 1'b1;
            ram_raddr = dn_nl[IW-1:0];
            state_nxt = S_DN_L;
          end else begin
            state_nxt = S_PLACE;
          end
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_PLACE: begin
        // The moving entry settles in the hole; the root copy follows any write to the root.
        ram_we    = 1'b1;
        ram_waddr = hole_r;
        ram_wdata = ent_r;
        if (hole_r == '0) begin
          root_nxt = ent_r;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The entry count never passes the heap depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("heap entry count above depth");

  // The controller never writes and reads the same RAM entry at one edge.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re && ram_waddr == ram_raddr))
    else $error("heap RAM read and write collide on one entry");

  // A push that is taken while the heap has room adds exactly one entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.req_type == REQ_PUSH && count_r != CW'(DEPTH))
    |=> count_r == $past(count_r) + CW'(1))
    else $error("accepted push did not add one entry");

  // A pop that is taken on an empty heap leaves it empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.req_type == REQ_POP && count_r == '0) |=> count_r == '0)
    else $error("pop on empty heap changed the entry count");

endmodule

@@ dv/binary_max_heap_priority_queue_tb.sv @@
// Testbench for binary_max_heap_priority_queue: directed and random push/pop items checked
// against an in-bench heap predictor, with random idle and stall bursts on both channels.
// Depends on bmhpq_pkg and the binary_max_heap_priority_queue RTL.
module binary_max_heap_priority_queue_tb
  import bmhpq_pkg::*;
();

  localparam int unsigned HEAP_DEPTH   = DEPTH_DEF;
  localparam int          RANDOM_ITEMS = 1350;
  // The last items run with no idling and no stalls.
  localparam int          CALM_ITEMS   = 150;
  localparam int          DRAIN_CYCLES = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  in_item_t  pend_items[$];
  out_item_t expected_tops[$];
  int        fail_count = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  logic      calm = 1'b0;

  // Predictor state: the heap as the block should hold it.
  logic [DATA_W-1:0]        heap_pay[HEAP_DEPTH];
  logic signed [PRIO_W-1:0] heap_pri[HEAP_DEPTH];
  int unsigned              heap_count = 0;
  // Entry count as tracked while the stimulus is built.
  int unsigned              plan_count = 0;

  binary_max_heap_priority_queue DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic [DATA_W-1:0]        td;
    logic signed [PRIO_W-1:0] tp;
    td = heap_pay[a];
    tp = heap_pri[a];
    heap_pay[a] = heap_pay[b];
    heap_pri[a] = heap_pri[b];
    heap_pay[b] = td;
    heap_pri[b] = tp;
  endfunction

  // Applies one request to the predicted heap and returns the top entry it leaves.
  function automatic out_item_t heap_after(in_item_t it);
    out_item_t   r;
    int unsigned i;
    int unsigned up;
    int unsigned lc;
    int unsigned rc;
    int unsigned best;
    r = '0;
    r.op_status = ST_OK;
    if (it.req_type == REQ_PUSH) begin
      if (heap_count >= HEAP_DEPTH) begin
        r.op_status = ST_FULL;
      end else begin
        i = heap_count;
        heap_pay[i] = it.item_data;
        heap_pri[i] = it.item_priority;
        heap_count++;
        // Sift up only while strictly greater than the parent.
        while (i > 0) begin
          up = (i - 1) / 2;
          if (heap_pri[i] <= heap_pri[up]) break;
          swap_entries(i, up);
          i = up;
        end
      end
    end else begin
      if (heap_count == 0) begin
        r.op_status = ST_EMPTY;
      end else begin
        heap_count--;
        heap_pay[0] = heap_pay[heap_count];
        heap_pri[0] = heap_pri[heap_count];
        i = 0;
        // Sift down; the left child wins a tie because the right must be strictly greater.
        forever begin
          lc = 2 * i + 1;
          rc = 2 * i + 2;
          best = i;
          if (lc < heap_count && heap_pri[lc] > heap_pri[best]) best = lc;
          if (rc < heap_count && heap_pri[rc] > heap_pri[best]) best = rc;
          if (best == i) break;
          swap_entries(i, best);
          i = best;
        end
      end
    end
    if (heap_count > 0) begin
      r.top_valid    = 1'b1;
      r.top_data     = heap_pay[0];
      r.top_priority = heap_pri[0];
    end
    r.entry_total = heap_count[TOTAL_W-1:0];
    return r;
  endfunction

  function automatic logic signed [PRIO_W-1:0] pick_priority();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $signed(PRIO_W'($urandom_range(0, 6))) - 3;
    if (sel < 7) begin
      case ($urandom_range(0, 3))
        0: return {1'b0, {(PRIO_W-1){1'b1}}};
        1: return {1'b1, {(PRIO_W-1){1'b0}}};
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic queue_push(logic [DATA_W-1:0] d, logic signed [PRIO_W-1:0] p);
    in_item_t it;
    it.req_type      = REQ_PUSH;
    it.item_data     = d;
    it.item_priority = p;
    pend_items.push_back(it);
    if (plan_count < HEAP_DEPTH) plan_count++;
  endtask

  // Pops carry random payload and priority bits, which the block must ignore.
  task automatic queue_pop();
    in_item_t it;
    it.req_type      = REQ_POP;
    it.item_data     = $urandom;
    it.item_priority = $urandom;
    pend_items.push_back(it);
    if (plan_count > 0) plan_count--;
  endtask

  task automatic build_stimulus();
    int mode;
    int span;
    int extra;
    // Directed: pop when empty, field extremes, ties with the parent and between children.
    queue_pop();
    queue_push('0, '0);
    queue_push('1, {1'b0, {(PRIO_W-1){1'b1}}});
    queue_push(32'hAAAA_AAAA, {1'b1, {(PRIO_W-1){1'b0}}});
    queue_push(32'h5555_5555, {1'b0, {(PRIO_W-1){1'b1}}});
    queue_push(32'h0000_0001, '1);
    queue_push(32'h8000_0000, '0);
    repeat (7) queue_pop();
    queue_push(32'h0000_0011, 32'sd5);
    queue_push(32'h0000_0022, 32'sd5);
    queue_push(32'h0000_0033, 32'sd5);
    queue_push(32'h0000_0044, 32'sd5);
    repeat (4) queue_pop();

    // Random: runs that fill to full, runs that drain to empty, and mixed noise.
    while (pend_items.size() < RANDOM_ITEMS + 22) begin
      mode = $urandom_range(0, 3);
      if (mode <= 1 && plan_count < HEAP_DEPTH) begin
        extra = $urandom_range(1, 4);
        while (extra > 0) begin
          if ($urandom_range(0, 9) == 0) begin
            queue_pop();
          end else begin
            if (plan_count == HEAP_DEPTH) extra--;
            queue_push($urandom, pick_priority());
          end
        end
      end else if (mode <= 2 && plan_count > 0) begin
        extra = $urandom_range(1, 3);
        while (extra > 0) begin
          if ($urandom_range(0, 9) == 0) begin
            queue_push($urandom, pick_priority());
          end else begin
            if (plan_count == 0) extra--;
            queue_pop();
          end
        end
      end else begin
        span = $urandom_range(20, 60);
        repeat (span) begin
          if ($urandom_range(0, 1) == 0) queue_push($urandom, pick_priority());
          else queue_pop();
        end
      end
    end
  endtask

  // Driver: presents pending items, holding each one steady while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      calm     <= 1'b0;
    end else begin
      calm <= (pend_items.size() <= CALM_ITEMS);
      if (in_valid && !in_stall) expected_tops.push_back(heap_after(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 14) - 1;
          in_valid <= 1'b0;
        end else begin
          in_data  <= pend_items.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: stalls in random bursts and checks every taken result against the oldest one due.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tops.size() == 0) begin
          $error("result item with nothing expected: %p", out_data);
          fail_count++;
        end else begin
          want = expected_tops.pop_front();
          if (out_data.top_valid !== want.top_valid) begin
            $error("top_valid: expected %0d, actual %0d", want.top_valid, out_data.top_valid);
            fail_count++;
          end
          if (out_data.top_data !== want.top_data) begin
            $error("top_data: expected %h, actual %h", want.top_data, out_data.top_data);
            fail_count++;
          end
          if (out_data.top_priority !== want.top_priority) begin
            $error("top_priority: expected %0d, actual %0d", want.top_priority,
                   out_data.top_priority);
            fail_count++;
          end
          if (out_data.entry_total !== want.entry_total) begin
            $error("entry_total: expected %0d, actual %0d", want.entry_total,
                   out_data.entry_total);
            fail_count++;
          end
          if (out_data.op_status !== want.op_status) begin
            $error("op_status: expected %0d, actual %0d", want.op_status, out_data.op_status);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pend_items.size() > 0 || in_valid) @(posedge clk);
    while (expected_tops.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_tops.size() == 0) begin
      $display("binary_max_heap_priority_queue_tb: PASS");
    end else begin
      $display("binary_max_heap_priority_queue_tb: FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("binary_max_heap_priority_queue_tb: FAIL");
    $finish;
  end

endmodule
